// ===== hw/rtl/protobuf_event_message_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the event message parser
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_EVENT_MESSAGE_PARSER_CORE_ASSERT_SVH
`define PROTOBUF_EVENT_MESSAGE_PARSER_CORE_ASSERT_SVH

// Plain property check
`define PEMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check
`define PEMP_ASSERT_IMP(label, ante, cons, msg) \
  `PEMP_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/pemp_pkg.sv =====
// ----------------------------------------------------------------------------
// pemp_pkg
// Types, codes and schema lookup of the event message parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pemp_pkg;

  localparam int MaxNestDefault = 3;
  localparam int LenBitsDefault = 32;
  localparam int ResultLimit    = 4;
  localparam logic [28:0] FnMax = 29'h1fff_ffff;

  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_TAG    = 6'b000010,
    PH_VARINT = 6'b000100,
    PH_FIXED  = 6'b001000,
    PH_LEN    = 6'b010000,
    PH_STRING = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    CL_UNKNOWN, CL_VARINT, CL_ZIGZAG, CL_FIXED, CL_STRING, CL_SUB
  } cls_e;

  typedef enum logic [1:0] {
    KIND_VALUE   = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  localparam logic [2:0] MT_TOP   = 3'd0;
  localparam logic [2:0] MT_QUERY = 3'd1;
  localparam logic [2:0] MT_EVENT = 3'd2;
  localparam logic [2:0] MT_STATE = 3'd3;
  localparam logic [2:0] MT_ATTR  = 3'd4;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_DOUBLE = 3'd1;
  localparam logic [2:0] WIRE_BYTES  = 3'd2;
  localparam logic [2:0] WIRE_FLOAT  = 3'd5;

  typedef struct packed {
    cls_e       cls;
    logic [2:0] expect_wire;
    logic [3:0] nbytes;
    logic [2:0] child;
  } class_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  mtype;
    logic [28:0] fnum;
    logic [2:0]  wtype;
    logic [63:0] value;
    logic        mis;
    logic        unk;
    logic        ovr;
    logic        trn;
  } res_t;

  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  shift;
    logic        done;
    logic [63:0] val;
  } varint_t;

  function automatic class_t classify(logic [2:0] mtype, logic [28:0] fn);
    class_t c;
    c = '{cls: CL_UNKNOWN, expect_wire: WIRE_BYTES, nbytes: 4'd0, child: MT_TOP};
    unique case (mtype)
      MT_TOP: begin
        if (fn == 29'd2) begin
          c.cls = CL_FIXED; c.expect_wire = WIRE_VARINT; c.nbytes = 4'd1;
        end else if (fn == 29'd3) begin
          c.cls = CL_STRING;
        end else if (fn == 29'd4) begin
          c.cls = CL_SUB; c.child = MT_STATE;
        end else if (fn == 29'd5) begin
          c.cls = CL_SUB; c.child = MT_QUERY;
        end else if (fn == 29'd6) begin
          c.cls = CL_SUB; c.child = MT_EVENT;
        end
      end
      MT_QUERY: begin
        if (fn == 29'd1) c.cls = CL_STRING;
      end
      MT_EVENT: begin
        if (fn == 29'd1 || fn == 29'd10) begin
          c.cls = CL_VARINT; c.expect_wire = WIRE_VARINT;
        end else if (fn == 29'd2 || fn == 29'd3 || fn == 29'd4 || fn == 29'd5 ||
                     fn == 29'd7) begin
          c.cls = CL_STRING;
        end else if (fn == 29'd8 || fn == 29'd15) begin
          c.cls = CL_FIXED; c.expect_wire = WIRE_FLOAT; c.nbytes = 4'd4;
        end else if (fn == 29'd9) begin
          c.cls = CL_SUB; c.child = MT_ATTR;
        end else if (fn == 29'd13) begin
          c.cls = CL_ZIGZAG; c.expect_wire = WIRE_VARINT;
        end else if (fn == 29'd14) begin
          c.cls = CL_FIXED; c.expect_wire = WIRE_DOUBLE; c.nbytes = 4'd8;
        end
      end
      MT_STATE: begin
        if (fn == 29'd1) begin
          c.cls = CL_VARINT; c.expect_wire = WIRE_VARINT;
        end else if (fn == 29'd2 || fn == 29'd3 || fn == 29'd4 || fn == 29'd5 ||
                     fn == 29'd7) begin
          c.cls = CL_STRING;
        end else if (fn == 29'd6) begin
          c.cls = CL_FIXED; c.expect_wire = WIRE_VARINT; c.nbytes = 4'd1;
        end else if (fn == 29'd8) begin
          c.cls = CL_FIXED; c.expect_wire = WIRE_FLOAT; c.nbytes = 4'd4;
        end
      end
      MT_ATTR: begin
        if (fn == 29'd1 || fn == 29'd2) c.cls = CL_STRING;
      end
      default: c.cls = CL_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic varint_t varint_step(logic [63:0] acc, logic [3:0] shift,
                                          logic [7:0] b);
    varint_t v;
    logic [6:0] amt;
    amt = 7'(shift) * 7'd7;
    v.acc = acc;
    if (shift < 4'd10) v.acc = acc | ({57'd0, b[6:0]} << amt);
    v.shift = shift + 4'd1;
    v.done  = 1'b0;
    v.val   = '0;
    if (!b[7]) begin
      v.done = 1'b1;
      v.val  = v.acc;
    end else if (v.shift >= 4'd10) begin
      v.done = 1'b1;
    end
    return v;
  endfunction

  function automatic res_t mk_res(kind_e kind, logic [2:0] mtype, logic [28:0] fnum,
                                  logic [2:0] wtype, logic [63:0] value, logic mis,
                                  logic unk, logic ovr, logic trn);
    res_t r;
    r = '{kind: kind, mtype: mtype, fnum: fnum, wtype: wtype, value: value,
          mis: mis, unk: unk, ovr: ovr, trn: trn};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/protobuf_event_message_parser_core.sv =====
// ----------------------------------------------------------------------------
// protobuf_event_message_parser_core
// Byte-serial parser for protobuf-encoded monitoring messages.
// ----------------------------------------------------------------------------
// Input channel: one message byte per request (data_byte_i, end_of_message_i)
// on in_valid_i / in_ready_o. Output channel: one record per request on
// out_valid_o / out_ready_i; last_result_o marks the final record of a byte.
// cfg_we_i writes prefix_bytes from cfg_wdata_i; write only while idle.
// Each accepted byte is parsed in the cycle it is taken; its zero to four
// records are registered into a two-slot record-group queue and shown on
// the output one record per cycle while out_ready_i is high. A byte is
// taken every cycle while a queue slot is free, so with a ready receiver
// bytes flow at one per cycle as long as each gives at most one record.
// Bytes that give no record pass without touching the queue.
// Reset clears the parser to the start of a message, prefix_bytes to zero
// and empties the queue. A stalled receiver holds the head record; input
// stays open until both queue slots are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module protobuf_event_message_parser_core #(
  parameter int MaxNest = pemp_pkg::MaxNestDefault,
  parameter int LenBits = pemp_pkg::LenBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       record_kind_o,
  output logic [2:0]       message_type_o,
  output logic [28:0]      field_id_o,
  output logic [2:0]       wire_type_o,
  output logic [63:0]      value_o,
  output logic             wire_mismatch_o,
  output logic             unknown_field_o,
  output logic             size_overrun_o,
  output logic             truncated_o,
  output logic             last_result_o
);

  import pemp_pkg::*;

  localparam int DW = $clog2(MaxNest);
  localparam int RW = LenBits + 1;
  localparam logic [RW-1:0] RemMin = {1'b1, {LenBits{1'b0}}};

  typedef struct packed {
    res_t [ResultLimit-1:0] rec;
    logic [2:0]             n;
  } group_t;

  logic [2:0]         prefix_q;
  phase_e             phase_q, phase_d, phase_w;
  logic [63:0]        acc_q, acc_d;
  logic [3:0]         shift_q, shift_d;
  logic [28:0]        field_q, field_d;
  logic [2:0]         wire_q, wire_d;
  logic [DW-1:0]      depth_q, depth_d;
  logic [2:0]         ltyp_q [MaxNest];
  logic [2:0]         ltyp_d [MaxNest];
  logic [RW-1:0]      lrem_q [MaxNest];
  logic [RW-1:0]      lrem_d [MaxNest];
  logic [LenBits-1:0] left_q, left_d;
  logic [2:0]         pcount_q, pcount_d;

  logic [2:0]  eff;
  logic [2:0]  mtype;
  class_t      cls_old, cls_new;
  varint_t     vs;
  logic [63:0] val, lval;
  logic        emit_v, do_close, clean;
  res_t        rec_v;
  group_t      grp_d;

  group_t      grp_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic [1:0]  idx_q;
  res_t        head;
  logic        in_fire, out_fire, push, pop;

  assign eff     = (prefix_q > 3'd4) ? 3'd4 : prefix_q;
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    shift_d  = shift_q;
    field_d  = field_q;
    wire_d   = wire_q;
    depth_d  = depth_q;
    ltyp_d   = ltyp_q;
    lrem_d   = lrem_q;
    left_d   = left_q;
    pcount_d = pcount_q;
    grp_d    = '0;
    emit_v   = 1'b0;
    do_close = 1'b0;
    rec_v    = '0;
    clean    = 1'b0;
    phase_w  = (phase_q == PH_PREFIX) ? PH_TAG : phase_q;
    mtype    = ltyp_q[depth_q];
    cls_old  = classify(mtype, field_q);
    cls_new  = cls_old;
    vs       = varint_step(acc_q, shift_q, data_byte_i);
    val      = vs.val;
    lval     = (|(vs.val >> LenBits)) ? 64'((65'd1 << LenBits) - 65'd1) : vs.val;

    if (phase_q == PH_PREFIX && pcount_q < eff) begin
      pcount_d = pcount_q + 3'd1;
    end else begin
      phase_d = phase_w;
      for (int i = 1; i < MaxNest; i++) begin
        if (i <= int'(depth_q) && lrem_q[i] != RemMin) lrem_d[i] = lrem_q[i] - RW'(1);
      end
      unique case (phase_w)
        PH_TAG: begin
          acc_d   = vs.acc;
          shift_d = vs.shift;
          if (vs.done) begin
            field_d = (|vs.val[63:32]) ? FnMax : vs.val[31:3];
            wire_d  = vs.val[2:0];
            acc_d   = '0;
            shift_d = '0;
            cls_new = classify(mtype, field_d);
            case (cls_new.cls)
              CL_UNKNOWN: begin
                emit_v   = 1'b1;
                rec_v    = mk_res(KIND_VALUE, mtype, field_d, wire_d, 64'd0,
                                  1'b0, 1'b1, 1'b0, 1'b0);
                do_close = 1'b1;
              end
              CL_VARINT, CL_ZIGZAG: phase_d = PH_VARINT;
              CL_FIXED: begin
                left_d  = LenBits'(cls_new.nbytes);
                phase_d = PH_FIXED;
              end
              default: phase_d = PH_LEN;
            endcase
          end
        end
        PH_VARINT: begin
          acc_d   = vs.acc;
          shift_d = vs.shift;
          if (vs.done) begin
            if (cls_old.cls == CL_ZIGZAG) val = (vs.val >> 1) ^ (64'd0 - {63'd0, vs.val[0]});
            emit_v   = 1'b1;
            rec_v    = mk_res(KIND_VALUE, mtype, field_q, wire_q, val,
                              wire_q != cls_old.expect_wire, 1'b0, 1'b0, 1'b0);
            acc_d    = '0;
            shift_d  = '0;
            phase_d  = PH_TAG;
            do_close = 1'b1;
          end
        end
        PH_FIXED: begin
          acc_d   = acc_q | ({56'd0, data_byte_i} << {shift_q[2:0], 3'b000});
          shift_d = shift_q + 4'd1;
          if (left_q != '0) left_d = left_q - LenBits'(1);
          if (left_d == '0) begin
            emit_v   = 1'b1;
            rec_v    = mk_res(KIND_VALUE, mtype, field_q, wire_q, acc_d,
                              wire_q != cls_old.expect_wire, 1'b0, 1'b0, 1'b0);
            acc_d    = '0;
            shift_d  = '0;
            phase_d  = PH_TAG;
            do_close = 1'b1;
          end
        end
        PH_LEN: begin
          acc_d   = vs.acc;
          shift_d = vs.shift;
          if (vs.done) begin
            emit_v  = 1'b1;
            rec_v   = mk_res(KIND_VALUE, mtype, field_q, wire_q, lval,
                             wire_q != cls_old.expect_wire, 1'b0, 1'b0, 1'b0);
            acc_d   = '0;
            shift_d = '0;
            phase_d = PH_TAG;
            if (cls_old.cls == CL_SUB && int'(depth_q) + 1 < MaxNest) begin
              depth_d         = depth_q + DW'(1);
              ltyp_d[depth_d] = cls_old.child;
              lrem_d[depth_d] = {1'b0, lval[LenBits-1:0]};
              do_close        = 1'b1;
            end else if (lval == 64'd0) begin
              do_close = 1'b1;
            end else begin
              left_d  = lval[LenBits-1:0];
              phase_d = PH_STRING;
            end
          end
        end
        PH_STRING: begin
          emit_v = 1'b1;
          rec_v  = mk_res(KIND_CONTENT, mtype, field_q, wire_q, {56'd0, data_byte_i},
                          1'b0, 1'b0, 1'b0, 1'b0);
          if (left_q != '0) left_d = left_q - LenBits'(1);
          if (left_d == '0) begin
            phase_d  = PH_TAG;
            do_close = 1'b1;
          end
        end
        default: phase_d = PH_TAG;
      endcase
    end

    if (emit_v) begin
      grp_d.rec[0] = rec_v;
      grp_d.n      = 3'd1;
    end
    if (do_close) begin
      for (int k = 0; k < MaxNest - 1; k++) begin
        if (depth_d != '0 &&
            (lrem_d[depth_d][LenBits] || lrem_d[depth_d] == '0)) begin
          if (grp_d.n < 3'(ResultLimit)) begin
            grp_d.rec[grp_d.n[1:0]] = mk_res(KIND_END, ltyp_d[depth_d], 29'd0, 3'd0,
                                             64'd0, 1'b0, 1'b0,
                                             lrem_d[depth_d][LenBits], 1'b0);
            grp_d.n = grp_d.n + 3'd1;
          end
          depth_d = depth_d - DW'(1);
        end
      end
    end

    if (end_of_message_i) begin
      clean = (phase_d == PH_PREFIX && pcount_d >= eff) ||
              (phase_d == PH_TAG && shift_d == '0 && depth_d == '0);
      if (grp_d.n < 3'(ResultLimit)) begin
        grp_d.rec[grp_d.n[1:0]] = mk_res(KIND_END, MT_TOP, 29'd0, 3'd0, 64'd0,
                                         1'b0, 1'b0, 1'b0, !clean);
        grp_d.n = grp_d.n + 3'd1;
      end
      phase_d  = PH_PREFIX;
      acc_d    = '0;
      shift_d  = '0;
      field_d  = '0;
      wire_d   = '0;
      depth_d  = '0;
      left_d   = '0;
      pcount_d = '0;
      for (int i = 0; i < MaxNest; i++) begin
        ltyp_d[i] = MT_TOP;
        lrem_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      phase_q  <= PH_PREFIX;
      acc_q    <= '0;
      shift_q  <= '0;
      field_q  <= '0;
      wire_q   <= '0;
      depth_q  <= '0;
      left_q   <= '0;
      pcount_q <= '0;
      for (int i = 0; i < MaxNest; i++) begin
        ltyp_q[i] <= MT_TOP;
        lrem_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) prefix_q <= cfg_wdata_i;
      if (in_fire) begin
        phase_q  <= phase_d;
        acc_q    <= acc_d;
        shift_q  <= shift_d;
        field_q  <= field_d;
        wire_q   <= wire_d;
        depth_q  <= depth_d;
        ltyp_q   <= ltyp_d;
        lrem_q   <= lrem_d;
        left_q   <= left_d;
        pcount_q <= pcount_d;
      end
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign push        = in_fire && (grp_d.n != 3'd0);
  assign pop         = out_fire && ({1'b0, idx_q} == grp_q[rd_q].n - 3'd1);
  assign head        = grp_q[rd_q].rec[idx_q];

  always_ff @(posedge clk_i) begin
    if (push) grp_q[wr_q] <= grp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (out_fire) idx_q <= pop ? 2'd0 : idx_q + 2'd1;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign record_kind_o   = head.kind;
  assign message_type_o  = head.mtype;
  assign field_id_o      = head.fnum;
  assign wire_type_o     = head.wtype;
  assign value_o         = head.value;
  assign wire_mismatch_o = head.mis;
  assign unknown_field_o = head.unk;
  assign size_overrun_o  = head.ovr;
  assign truncated_o     = head.trn;
  assign last_result_o   = ({1'b0, idx_q} == grp_q[rd_q].n - 3'd1);

`include "protobuf_event_message_parser_core_assert.svh"

  `PEMP_ASSERT(a_cnt_range, cnt_q != 2'd3, "record queue count out of range")
  `PEMP_ASSERT_IMP(a_head_nonempty, out_valid_o, {1'b0, idx_q} < grp_q[rd_q].n, "head past group")
  `PEMP_ASSERT_IMP(a_no_overfill, cnt_q == 2'd2, !in_ready_o, "input open with full queue")

endmodule

`default_nettype wire
